// File: rtl/stsi_pkg.sv
// ----------------------------------------------------------------------------
// stsi_pkg: shared types and constants of the sorted table search/insert core
// Table geometry, key width, state, status and register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stsi_pkg;

    localparam int TBL_DEPTH = 64;
    localparam int KEY_W     = 32;
    localparam int IN_KEY_W  = 32;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int CW        = $clog2(TBL_DEPTH + 1);
    localparam int POS_W     = 7;
    localparam int STAT_W    = 2;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [AW-1:0]    t_addr;
    typedef logic [CW-1:0]    t_cnt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_SHIFT,
        S_PUT
    } t_state;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        REG_UNIQUE = 1'b0,
        REG_ORDER  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        FN_SEARCH = 1'b0,
        FN_INSERT = 1'b1
    } t_func;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

`default_nettype wire

// File: rtl/stsi_ram.sv
// ----------------------------------------------------------------------------
// stsi_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/stsi_cmp.sv
// ----------------------------------------------------------------------------
// stsi_cmp: shared key comparator
// Compares a stored key against the probe key, unsigned or two's complement.
// ----------------------------------------------------------------------------
`default_nettype none

module stsi_cmp import stsi_pkg::*; (
    input  wire  t_key i_stored,
    input  wire  t_key i_probe,
    input  wire        i_signed,
    output t_cmp       o_cmp
);

    t_key a;
    t_key b;

    always_comb begin
        a = i_stored;
        b = i_probe;
        if (i_signed) begin
            a[KEY_W-1] = ~i_stored[KEY_W-1];
            b[KEY_W-1] = ~i_probe[KEY_W-1];
        end
        o_cmp.lt = (a < b);
        o_cmp.eq = (a == b);
    end

endmodule

`default_nettype wire

// File: rtl/sorted_table_search_insert_core.sv
// ----------------------------------------------------------------------------
// sorted_table_search_insert_core: sorted key table with search and insert
// Binary search over a RAM-held ascending table; insert shifts entries up.
// ----------------------------------------------------------------------------
// One command at a time: start is taken while busy is low. The lookup runs
// its probes through a single comparator and the table RAM (registered
// read), at most 7 probes at 64 entries. An accepted insert then moves
// entries with one RAM read and one RAM write per cycle, from the top of
// the table down to the insert position, and then writes the new key.
// The strobe o_valid is high for exactly one cycle and is not held;
// found, position and status stay until the next result, and the
// receiver cannot stall it.
// The table needs no clearing pass after reset.
`default_nettype none

module sorted_table_search_insert_core import stsi_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire                  i_func,
    input  wire  [IN_KEY_W-1:0]  i_key,
    output logic                 o_valid,
    output logic                 o_found,
    output logic [POS_W-1:0]     o_position,
    output logic [STAT_W-1:0]    o_status,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire                  i_cfg_index,
    input  wire                  i_cfg_data
);

    t_state  r_state, n_state;
    logic    r_func;
    t_key    r_key;
    t_cnt    r_lo, n_lo;
    t_cnt    r_hx, n_hx;
    t_cnt    r_mid, n_mid;
    logic    r_hit, n_hit;
    t_cnt    r_count, n_count;
    t_cnt    r_ptr, n_ptr;
    t_addr   r_wa, n_wa;
    logic    r_pend, n_pend;
    logic    r_unique;
    logic    r_order;

    logic    n_valid;
    t_status n_status;

    logic    ram_we;
    t_addr   ram_waddr;
    t_key    ram_wdata;
    t_addr   ram_raddr;
    t_key    ram_rdata;
    t_cmp    cmp;

    logic    accept;
    logic    more;
    logic    reject;
    logic [CW:0] mid_sum;
    t_cnt    mid;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign more        = (r_lo < r_hx);
    assign mid_sum     = {1'b0, r_lo} + {1'b0, r_hx} - 1'b1;
    assign mid         = mid_sum[CW:1];
    assign reject      = (r_hit && r_unique) || (r_count == CW'(TBL_DEPTH));

    stsi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TBL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stsi_cmp u_cmp (
        .i_stored (ram_rdata),
        .i_probe  (r_key),
        .i_signed (r_order),
        .o_cmp    (cmp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (more) begin
                    n_state = S_CMP;
                end else if (r_func == FN_INSERT && !reject) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CMP: begin
                n_state = S_SEARCH;
            end
            S_SHIFT: begin
                if (r_ptr == r_lo && !r_pend) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_lo      = r_lo;
        n_hx      = r_hx;
        n_mid     = r_mid;
        n_hit     = r_hit;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_wa      = r_wa;
        n_pend    = 1'b0;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = ram_rdata;
        ram_raddr = AW'(mid);
        unique case (r_state)
            S_IDLE: begin
                n_lo  = '0;
                n_hx  = r_count;
                n_hit = 1'b0;
            end
            S_SEARCH: begin
                n_mid = mid;
                n_ptr = r_count;
                if (!more) begin
                    if (r_func == FN_INSERT && r_hit && r_unique) begin
                        n_valid  = 1'b1;
                        n_status = ST_DUP;
                    end else if (r_func == FN_INSERT && reject) begin
                        n_valid  = 1'b1;
                        n_status = ST_FULL;
                    end else if (r_func == FN_SEARCH) begin
                        n_valid = 1'b1;
                    end
                end
            end
            S_CMP: begin
                if (cmp.lt) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hx = r_mid;
                    if (cmp.eq) begin
                        n_hit = 1'b1;
                        if (r_unique) begin
                            n_lo = r_mid;
                        end
                    end
                end
            end
            S_SHIFT: begin
                ram_we    = r_pend;
                ram_raddr = AW'(r_ptr - 1'b1);
                if (r_ptr > r_lo) begin
                    n_wa   = AW'(r_ptr);
                    n_ptr  = r_ptr - 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_lo);
                ram_wdata = r_key;
                n_count   = r_count + 1'b1;
                n_valid   = 1'b1;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_unique <= 1'b1;
            r_order  <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            o_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_UNIQUE: r_unique <= i_cfg_data;
                    REG_ORDER:  r_order  <= i_cfg_data;
                    default:    r_order  <= r_order;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hx  <= n_hx;
        r_mid <= n_mid;
        r_hit <= n_hit;
        r_ptr <= n_ptr;
        r_wa  <= n_wa;
        if (accept) begin
            r_func <= i_func;
            r_key  <= KEY_W'(i_key);
        end
        if (n_valid) begin
            o_found    <= r_hit;
            o_position <= POS_W'(r_lo);
            o_status   <= n_status;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TBL_DEPTH))
        else $error("entry count beyond table depth");

    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo <= r_hx && r_hx <= r_count))
        else $error("search bounds out of order");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_count == CW'(TBL_DEPTH)))
        else $error("full status with room left");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_func == FN_INSERT && o_status == ST_OK)
        |-> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("insert did not advance entry count");
`endif

endmodule

`default_nettype wire

// File: tb/tb_sorted_table_search_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_search_insert_core: self-checking bench for the sorted table
// Drives search and insert commands, with directed extremes first and then
// random phases over three of the four register settings. A bit-accurate
// table model, or a directed row, predicts found, position and status for
// each accepted command; every result strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_sorted_table_search_insert_core import stsi_pkg::*; ();

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        t_status          st;
    } t_result;

    typedef struct packed {
        logic     is_cfg;
        t_reg_idx ridx;
        t_func    fn;
        t_key     key;
        logic     known;
        t_result  want;
    } t_dir_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic                i_func      = 1'b0;
    logic [IN_KEY_W-1:0] i_key       = '0;
    logic                o_valid;
    logic                o_found;
    logic [POS_W-1:0]    o_position;
    logic [STAT_W-1:0]   o_status;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = 1'b0;
    logic                i_cfg_data  = 1'b0;

    sorted_table_search_insert_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timeout at %0t", $time);
        $display("Verification failed");
        $finish;
    end

    // table model
    t_key        tbl_keys [TBL_DEPTH];
    int          tbl_count    = 0;
    logic        uniq_mode    = 1'b1;
    logic        signed_order = 1'b0;

    t_result     awaited_lookups [$];
    t_dir_row    dir_rows [$];
    int          idle_pct = 0;
    int          errors   = 0;
    int          n_checked = 0;
    int          n_search = 0;
    int          n_insert = 0;
    int          n_dup    = 0;
    int          n_full   = 0;
    int          n_hit    = 0;

    function automatic t_key order_map(input t_key k);
        return signed_order ? (k ^ (t_key'(1) << (KEY_W - 1))) : k;
    endfunction

    function automatic t_result table_lookup_insert(input t_func fn, input t_key k);
        t_result res;
        int      lo;
        int      hi;
        int      mid;
        logic    hit;
        t_key    a;
        t_key    b;
        lo  = 0;
        hi  = tbl_count - 1;
        hit = 1'b0;
        b   = order_map(k);
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            a   = order_map(tbl_keys[mid]);
            if (a < b) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
                if (a == b) begin
                    hit = 1'b1;
                    if (uniq_mode)
                        lo = mid;
                end
            end
        end
        res.found = hit;
        res.pos   = lo[POS_W-1:0];
        res.st    = ST_OK;
        if (fn == FN_INSERT) begin
            if (hit && uniq_mode) begin
                res.st = ST_DUP;
            end else if (tbl_count >= TBL_DEPTH) begin
                res.st = ST_FULL;
            end else begin
                for (int i = tbl_count; i > lo; i--)
                    tbl_keys[i] = tbl_keys[i-1];
                tbl_keys[lo] = k;
                tbl_count++;
            end
        end
        return res;
    endfunction

    function automatic t_key pick_key();
        t_key k;
        k = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: if (tbl_count > 0) k = tbl_keys[$urandom_range(tbl_count - 1)];
            4:          if (tbl_count > 0) k = tbl_keys[$urandom_range(tbl_count - 1)] + 1'b1;
            5:          if (tbl_count > 0) k = tbl_keys[$urandom_range(tbl_count - 1)] - 1'b1;
            6: begin
                case ($urandom_range(5))
                    0:       k = '0;
                    1:       k = '1;
                    2:       k = t_key'(1) << (KEY_W - 1);
                    3:       k = ~(t_key'(1) << (KEY_W - 1));
                    4:       k = t_key'(1);
                    default: k = ~t_key'(1);
                endcase
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    function automatic t_dir_row cmd_row(input t_func fn, input t_key k);
        t_dir_row r;
        r        = '0;
        r.fn     = fn;
        r.key    = k;
        return r;
    endfunction

    function automatic t_dir_row known_row(input t_func fn, input t_key k, input logic found,
                                           input int pos, input t_status st);
        t_dir_row r;
        r            = cmd_row(fn, k);
        r.known      = 1'b1;
        r.want.found = found;
        r.want.pos   = pos[POS_W-1:0];
        r.want.st    = st;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input t_reg_idx idx, input logic val);
        t_dir_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.ridx   = idx;
        r.key[0] = val;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            if (awaited_lookups.size() == 0) begin
                $display("%0t: result with nothing expected: found %0d position %0d status %0d",
                         $time, o_found, o_position, o_status);
                errors++;
            end else begin
                want = awaited_lookups.pop_front();
                n_checked++;
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch: expected %0d actual %0d",
                             $time, want.found, o_found);
                    errors++;
                end
                if (o_position !== want.pos) begin
                    $display("%0t: position mismatch: expected %0d actual %0d",
                             $time, want.pos, o_position);
                    errors++;
                end
                if (o_status !== want.st) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.st, o_status);
                    errors++;
                end
            end
        end
    end

    task automatic run_cmd(input t_func fn, input t_key k, input logic known,
                           input t_result known_want);
        t_result want;
        start  <= 1'b1;
        i_func <= fn;
        i_key  <= k;
        do @(posedge i_clk); while (busy);
        want = table_lookup_insert(fn, k);
        if (fn == FN_INSERT)
            n_insert++;
        else
            n_search++;
        if (want.st == ST_DUP)
            n_dup++;
        if (want.st == ST_FULL)
            n_full++;
        if (want.found)
            n_hit++;
        awaited_lookups.push_back(known ? known_want : want);
        // hold off the next transaction
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (awaited_lookups.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_UNIQUE)
            uniq_mode = val;
        else
            signed_order = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic uniq, input logic ord, input int idle,
                             input int ins_pct, input int count);
        t_func fn;
        drain_results();
        write_reg(REG_UNIQUE, uniq);
        write_reg(REG_ORDER, ord);
        idle_pct = idle;
        for (int n = 0; n < count; n++) begin
            fn = ($urandom_range(99) < ins_pct) ? FN_INSERT : FN_SEARCH;
            run_cmd(fn, pick_key(), 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        t_dir_row row;
        dir_rows.push_back(known_row(FN_SEARCH, 32'h0000_0000, 1'b0, 0, ST_OK));
        dir_rows.push_back(known_row(FN_SEARCH, 32'hFFFF_FFFF, 1'b0, 0, ST_OK));
        dir_rows.push_back(known_row(FN_INSERT, 32'h7FFF_FFFF, 1'b0, 0, ST_OK));
        dir_rows.push_back(known_row(FN_INSERT, 32'h0000_0000, 1'b0, 0, ST_OK));
        dir_rows.push_back(known_row(FN_INSERT, 32'h0000_0000, 1'b1, 0, ST_DUP));
        dir_rows.push_back(known_row(FN_INSERT, 32'h7FFF_FFFF, 1'b1, 1, ST_DUP));
        dir_rows.push_back(known_row(FN_SEARCH, 32'hFFFF_FFFF, 1'b0, 2, ST_OK));
        dir_rows.push_back(known_row(FN_SEARCH, 32'h8000_0000, 1'b0, 2, ST_OK));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h4000_0000));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h0000_0001));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h7FFF_FFFE));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h1234_5678));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h2AAA_AAAA));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h5555_5555));
        dir_rows.push_back(cmd_row(FN_SEARCH, 32'h4000_0000));
        dir_rows.push_back(cmd_row(FN_SEARCH, 32'h0000_0000));
        dir_rows.push_back(cmd_row(FN_SEARCH, 32'h3FFF_FFFF));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h4000_0000));
        dir_rows.push_back(cmd_row(FN_SEARCH, 32'h7FFF_FFFF));
        dir_rows.push_back(cfg_row(REG_UNIQUE, 1'b0));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h4000_0000));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h4000_0000));
        dir_rows.push_back(cmd_row(FN_SEARCH, 32'h4000_0000));
        dir_rows.push_back(cmd_row(FN_INSERT, 32'h0000_0000));
        dir_rows.push_back(cfg_row(REG_UNIQUE, 1'b1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 9;
        for (int r = 0; r < dir_rows.size(); r++) begin
            row = dir_rows[r];
            if (row.is_cfg) begin
                drain_results();
                write_reg(row.ridx, row.key[0]);
            end else begin
                run_cmd(row.fn, row.key, row.known, row.want);
            end
        end

        run_phase(1'b0, 1'b1,  9, 10, 330);
        run_phase(1'b1, 1'b1, 82, 20, 330);
        run_phase(1'b0, 1'b0,  0, 30, 330);

        drain_results();
        repeat (100) @(posedge i_clk);

        $display("Checked %0d results: %0d searches, %0d inserts, %0d hits", n_checked,
                 n_search, n_insert, n_hit);
        $display("Rejected %0d duplicates and %0d full-table inserts; table holds %0d keys",
                 n_dup, n_full, tbl_count);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
